/* hdl/rso_pkg.sv */
// ----------------------------------------------------------------------------
// rso_pkg
// Shared types and helpers for the rectangle set overlap checker: request and
// result payloads, stored rectangle format, bounding box math.
// ----------------------------------------------------------------------------
`default_nettype none

package rso_pkg;

	// input request: one rectangle
	typedef struct packed {
		logic              to_set_b;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]       width;
		logic [14:0]       height;
		logic              last;
	} rso_item_t;

	// result of one overlap check
	typedef struct packed {
		logic bounds_touch;
		logic collide;
		logic dropped;
	} rso_result_t;

	// rectangle as kept in the set stores
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]       width;
		logic [14:0]       height;
	} rso_rect_t;

	localparam int unsigned RECT_W = $bits(rso_rect_t);

	// box with resolved edges, 17-bit signed
	typedef struct packed {
		logic signed [16:0] l;
		logic signed [16:0] t;
		logic signed [16:0] r;
		logic signed [16:0] b;
	} rso_box_t;

	// check job handed from the front to the back
	typedef struct packed {
		logic vld;
		logic broad;
		logic dropped;
		logic busy;
	} rso_job_t;

	// back to front handshake
	typedef struct packed {
		logic take;
		logic release_sets;
	} rso_ctl_t;

	function automatic rso_box_t box_of(input rso_rect_t rc);
		rso_box_t bx;
		bx.l = 17'($signed(rc.left));
		bx.t = 17'($signed(rc.top));
		bx.r = $signed(bx.l) + $signed({2'b00, rc.width});
		bx.b = $signed(bx.t) + $signed({2'b00, rc.height});
		return bx;
	endfunction

	function automatic rso_box_t box_merge(input rso_box_t cur, input rso_box_t add);
		rso_box_t bx;
		bx.l = ($signed(add.l) < $signed(cur.l)) ? add.l : cur.l;
		bx.t = ($signed(add.t) < $signed(cur.t)) ? add.t : cur.t;
		bx.r = ($signed(add.r) > $signed(cur.r)) ? add.r : cur.r;
		bx.b = ($signed(add.b) > $signed(cur.b)) ? add.b : cur.b;
		return bx;
	endfunction

	// touching edges count as overlap
	function automatic logic box_touch(input rso_box_t p, input rso_box_t q);
		return !(($signed(p.l) > $signed(q.r)) || ($signed(q.l) > $signed(p.r)) ||
			($signed(p.t) > $signed(q.b)) || ($signed(q.t) > $signed(p.b)));
	endfunction

endpackage

`default_nettype wire

/* hdl/rect_set_overlap_check.sv */
// Loading takes one rectangle request per cycle with no stall while a set fills.
// After the request marked last, input stays full until the back takes the job if
// the broad test fails, else through the pair sweep (one pair per cycle through the
// registered store reads, stopping at the first hit), more while the back waits
// to queue an earlier result; the result is queued once ST_EMIT finds queue room.
// Reset clears counts, flags, control and the result queue; stores are not cleared.
// ----------------------------------------------------------------------------
// rect_set_overlap_check
// Two sets of axis-aligned rectangles, bounding-box broad test and pairwise
// narrow test, one flag result per check.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_set_overlap_check import rso_pkg::*; #(
	parameter int unsigned SET_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire rso_item_t   item,
	output logic             empty,
	input  wire logic        pop,
	output rso_result_t      result
);

	localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

	logic             wr_a_en, wr_b_en;
	logic [IDX_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
	rso_rect_t        wr_data, rd_a_data, rd_b_data;
	rso_job_t         job;
	rso_ctl_t         ctl;
	logic [CNT_W-1:0] job_cnt_a, job_cnt_b;

	// loading and broad test
	rso_front #(.SET_DEPTH(SET_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.wr_a_en   (wr_a_en),
		.wr_b_en   (wr_b_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job       (job),
		.job_cnt_a (job_cnt_a),
		.job_cnt_b (job_cnt_b),
		.ctl       (ctl)
	);

	// set stores
	rso_ram #(.WIDTH(RECT_W), .DEPTH(SET_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (wr_a_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_a_addr),
		.rdata (rd_a_data)
	);

	rso_ram #(.WIDTH(RECT_W), .DEPTH(SET_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (wr_b_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_b_addr),
		.rdata (rd_b_data)
	);

	// pair sweep and result queue
	rso_back #(.SET_DEPTH(SET_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_cnt_a (job_cnt_a),
		.job_cnt_b (job_cnt_b),
		.ctl       (ctl),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// a pending job stays until the back takes it
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		job.vld && !ctl.take |=> job.vld)
		else $error("check job lost before take");

	// stores are released only while the front waits on them
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.release_sets |-> job.busy)
		else $error("set release without a running check");

	// no store write while the back may still read the sets
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_a_en || wr_b_en) |-> !job.busy)
		else $error("store write during pair sweep");

endmodule

`default_nettype wire

/* hdl/rso_ram.sv */
// ----------------------------------------------------------------------------
// rso_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rso_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/rso_front.sv */
// ----------------------------------------------------------------------------
// rso_front
// Loads rectangles into set A or B, tracks each set's bounding box, runs the
// broad test after the last request and hands a check job to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rso_front import rso_pkg::*; #(
	parameter int unsigned SET_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire rso_item_t                           item,
	output logic                                     wr_a_en,
	output logic                                     wr_b_en,
	output logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] wr_addr,
	output rso_rect_t                                wr_data,
	output rso_job_t                                 job,
	output logic [$clog2(SET_DEPTH + 1)-1:0]         job_cnt_a,
	output logic [$clog2(SET_DEPTH + 1)-1:0]         job_cnt_b,
	input  wire rso_ctl_t                            ctl
);

	localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic             overflow_q;
	logic             chk_q;
	logic             busy_q;
	logic             job_vld_q;
	logic             job_broad_q;
	logic             job_drop_q;
	logic [CNT_W-1:0] job_cnt_a_q, job_cnt_b_q;
	rso_box_t         box_a_q, box_b_q;

	logic     acc;
	logic     a_room, b_room;
	logic     tgt_room;
	rso_box_t box_in;
	logic     broad_now;

	// request decode and store write
	always_comb begin
		full      = chk_q | busy_q;
		acc       = push & ~full;
		a_room    = (cnt_a_q != CNT_W'(SET_DEPTH));
		b_room    = (cnt_b_q != CNT_W'(SET_DEPTH));
		tgt_room  = item.to_set_b ? b_room : a_room;
		wr_data   = '{left: item.left, top: item.top, width: item.width,
			height: item.height};
		box_in    = box_of(wr_data);
		wr_a_en   = acc & ~item.to_set_b & a_room;
		wr_b_en   = acc & item.to_set_b & b_room;
		wr_addr   = item.to_set_b ? cnt_b_q[IDX_W-1:0] : cnt_a_q[IDX_W-1:0];
		broad_now = (cnt_a_q != '0) && (cnt_b_q != '0) && box_touch(box_a_q, box_b_q);
	end

	// counts, overflow flag and job handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
			overflow_q <= 1'b0;
			chk_q      <= 1'b0;
			busy_q     <= 1'b0;
			job_vld_q  <= 1'b0;
		end else begin
			if (wr_a_en) begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			end
			if (wr_b_en) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			end
			if (acc && !tgt_room) begin
				overflow_q <= 1'b1;
			end
			if (acc && item.last) begin
				chk_q <= 1'b1;
			end
			if (chk_q) begin
				chk_q      <= 1'b0;
				job_vld_q  <= 1'b1;
				busy_q     <= 1'b1;
				cnt_a_q    <= '0;
				cnt_b_q    <= '0;
				overflow_q <= 1'b0;
			end
			if (ctl.take) begin
				job_vld_q <= 1'b0;
			end
			if (ctl.release_sets) begin
				busy_q <= 1'b0;
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (chk_q) begin
			job_broad_q <= broad_now;
			job_drop_q  <= overflow_q;
			job_cnt_a_q <= cnt_a_q;
			job_cnt_b_q <= cnt_b_q;
		end
	end

	// bounding boxes, first rectangle of a set loads the box
	always_ff @(posedge clk) begin
		if (wr_a_en) begin
			box_a_q <= (cnt_a_q == '0) ? box_in : box_merge(box_a_q, box_in);
		end
		if (wr_b_en) begin
			box_b_q <= (cnt_b_q == '0) ? box_in : box_merge(box_b_q, box_in);
		end
	end

	assign job = '{vld: job_vld_q, broad: job_broad_q, dropped: job_drop_q,
		busy: busy_q};
	assign job_cnt_a = job_cnt_a_q;
	assign job_cnt_b = job_cnt_b_q;

endmodule

`default_nettype wire

/* hdl/rso_back.sv */
// ----------------------------------------------------------------------------
// rso_back
// Takes check jobs, sweeps all A/B pairs out of the set stores until a hit or
// the last pair, and queues the result for the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module rso_back import rso_pkg::*; #(
	parameter int unsigned SET_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rso_job_t                            job,
	input  wire logic [$clog2(SET_DEPTH + 1)-1:0]    job_cnt_a,
	input  wire logic [$clog2(SET_DEPTH + 1)-1:0]    job_cnt_b,
	output rso_ctl_t                                 ctl,
	output logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] rd_a_addr,
	output logic [((SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1)-1:0] rd_b_addr,
	input  wire rso_rect_t                           rd_a_data,
	input  wire rso_rect_t                           rd_b_data,
	output logic                                     empty,
	input  wire logic                                pop,
	output rso_result_t                              result
);

	localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic             bounds_q, drop_q, hit_q;
	logic             rd_vld_s1;

	rso_result_t      fifo_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       fill_q;

	logic take, i_last, j_last, hit_now, res_push, res_pop;

	// sweep control
	always_comb begin
		take     = (state_q == ST_IDLE) && job.vld;
		i_last   = (CNT_W'(i_q) == cnt_a_q - CNT_W'(1));
		j_last   = (CNT_W'(j_q) == cnt_b_q - CNT_W'(1));
		hit_now  = rd_vld_s1 && box_touch(box_of(rd_a_data), box_of(rd_b_data));
		res_push = (state_q == ST_EMIT) && (fill_q != 2'd2);
		res_pop  = pop && (fill_q != 2'd0);
		ctl.take         = take;
		ctl.release_sets = (take && !job.broad) || (state_q == ST_DRAIN);
		rd_a_addr = i_q;
		rd_b_addr = j_q;
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= job.broad ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (hit_q || hit_now || (i_last && j_last)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// job copy, pair indexes and hit flag
	always_ff @(posedge clk) begin
		if (take) begin
			cnt_a_q  <= job_cnt_a;
			cnt_b_q  <= job_cnt_b;
			bounds_q <= job.broad;
			drop_q   <= job.dropped;
			hit_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_SCAN) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (res_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(res_push) - 2'(res_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			fifo_q[wr_ptr_q] <= '{bounds_touch: bounds_q, collide: hit_q,
				dropped: drop_q};
		end
	end

	assign empty  = (fill_q == 2'd0);
	assign result = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire
